// ===== design/mftp_pkg.sv =====
// Package for the MIDI file track parser: byte roles, error codes, the byte item
// passed from front to back and the classified-byte result record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mftp_pkg;

   localparam logic [3:0] ROLE_FHDR   = 4'd0;
   localparam logic [3:0] ROLE_THDR   = 4'd1;
   localparam logic [3:0] ROLE_DELTA  = 4'd2;
   localparam logic [3:0] ROLE_STATUS = 4'd3;
   localparam logic [3:0] ROLE_CDATA  = 4'd4;
   localparam logic [3:0] ROLE_SXLEN  = 4'd5;
   localparam logic [3:0] ROLE_SXDATA = 4'd6;
   localparam logic [3:0] ROLE_MTYPE  = 4'd7;
   localparam logic [3:0] ROLE_MLEN   = 4'd8;
   localparam logic [3:0] ROLE_MDATA  = 4'd9;
   localparam logic [3:0] ROLE_IGNORE = 4'd10;

   localparam logic [2:0] ERR_OK      = 3'd0;
   localparam logic [2:0] ERR_FHDR    = 3'd1;
   localparam logic [2:0] ERR_TRKID   = 3'd2;
   localparam logic [2:0] ERR_UNKNOWN = 3'd3;
   localparam logic [2:0] ERR_HALTED  = 3'd4;

   localparam logic [7:0] META_EOT = 8'h2F;

   // Item kept in the queue between the front and the back.
   typedef struct packed {
      logic [7:0] data;
   } item_type;

   // Result record.
   typedef struct packed {
      logic [3:0]  role;
      logic [7:0]  value;
      logic [7:0]  ev_type;
      logic [3:0]  chan;
      logic [7:0]  meta;
      logic [31:0] stamp;
      logic [31:0] delta;
      logic [31:0] length;
      logic        ev_end;
      logic        trk_end;
      logic [15:0] trk_num;
      logic [2:0]  err;
   } result_type;

   function automatic logic [31:0] chan_count(input logic [7:0] s);
      logic [3:0] hi;
      hi = s[7:4];
      return (hi == 4'hC || hi == 4'hD) ? 32'd1 : 32'd2;
   endfunction

   function automatic logic [7:0] file_id(input logic [1:0] p);
      logic [7:0] r;
      unique case (p)
         2'd0: r = 8'h4D;
         2'd1: r = 8'h54;
         2'd2: r = 8'h68;
         default: r = 8'h64;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] track_id(input logic [1:0] p);
      logic [7:0] r;
      unique case (p)
         2'd0: r = 8'h4D;
         2'd1: r = 8'h54;
         2'd2: r = 8'h72;
         default: r = 8'h6B;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/mftp_queue.sv =====
// Two-entry queue between the byte front end and the parse engine.
// Depends on mftp_pkg for the item record.
`timescale 1ns / 1ps
`default_nettype none
module mftp_queue
   import mftp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   output logic          out_valid,
   input  wire logic     out_ready,
   output item_type      out_item
);
   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end
endmodule
`default_nettype wire

// ===== design/mftp_engine.sv =====
// Parse engine: walks the file structure one byte per cycle, unless the result
// register is held by a stalled receiver, and registers the labeled result. Depends on mftp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mftp_engine
   import mftp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   output logic          out_valid,
   input  wire logic     out_ready,
   output result_type    out_res
);
   typedef enum logic [10:0] {
      PH_FHDR   = 11'b00000000001,
      PH_THDR   = 11'b00000000010,
      PH_DELTA  = 11'b00000000100,
      PH_STATUS = 11'b00000001000,
      PH_CDATA  = 11'b00000010000,
      PH_SXLEN  = 11'b00000100000,
      PH_SXDATA = 11'b00001000000,
      PH_MTYPE  = 11'b00010000000,
      PH_MLEN   = 11'b00100000000,
      PH_MDATA  = 11'b01000000000,
      PH_DONE   = 11'b10000000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  hpos_ff, hpos_in;
   logic [15:0] fmt_ff, fmt_in, ntrk_ff, ntrk_in, started_ff, started_in;
   logic        idm_ff, idm_in, endp_ff, endp_in, halt_ff, halt_in;
   logic [31:0] vlq_ff, vlq_in, tick_ff, tick_in, delta_ff, delta_in;
   logic [31:0] left_ff, left_in, plen_ff, plen_in;
   logic [7:0]  rs_ff, rs_in, est_ff, est_in, mk_ff, mk_in;
   logic        ovalid_ff;
   result_type  res_ff, r;
   logic        take;
   logic [7:0]  b;
   logic [31:0] vlq_next, left_dec;
   logic        cont;

   assign in_ready  = !ovalid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = ovalid_ff;
   assign out_res   = res_ff;
   assign b         = in_item.data;

   // Next state and result for one byte.
   always_comb begin
      phase_in = phase_ff; hpos_in = hpos_ff; fmt_in = fmt_ff; ntrk_in = ntrk_ff;
      started_in = started_ff; idm_in = idm_ff; endp_in = endp_ff;
      halt_in = halt_ff; vlq_in = vlq_ff; tick_in = tick_ff; delta_in = delta_ff;
      left_in = left_ff; plen_in = plen_ff; rs_in = rs_ff; est_in = est_ff;
      mk_in = mk_ff;
      r = '0;
      r.value = b;
      cont = b[7];
      vlq_next = {vlq_ff[24:0], b[6:0]};
      left_dec = left_ff - 32'd1;
      if (halt_ff) begin
         r.role = ROLE_IGNORE;
         r.err  = ERR_HALTED;
      end else begin
         unique case (phase_ff)
            PH_FHDR: begin
               r.role = ROLE_FHDR;
               if (hpos_ff < 4'd4) begin
                  idm_in = (hpos_ff == 4'd0 ? 1'b1 : idm_ff) && (b == file_id(hpos_ff[1:0]));
               end else if (hpos_ff == 4'd8 || hpos_ff == 4'd9) begin
                  fmt_in = {fmt_ff[7:0], b};
               end else if (hpos_ff == 4'd10 || hpos_ff == 4'd11) begin
                  ntrk_in = {ntrk_ff[7:0], b};
               end
               if (hpos_ff >= 4'd13) begin
                  hpos_in = 4'd0;
                  if (!idm_ff || (fmt_ff == 16'd0 && ntrk_ff != 16'd1)) begin
                     r.err   = ERR_FHDR;
                     halt_in = 1'b1;
                  end else if (ntrk_ff == 16'd0) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_THDR;
                  end
               end else begin
                  hpos_in = hpos_ff + 4'd1;
               end
            end
            PH_THDR: begin
               r.role = ROLE_THDR;
               started_in = (hpos_ff == 4'd0) ? started_ff + 16'd1 : started_ff;
               if (hpos_ff < 4'd4) begin
                  idm_in = (hpos_ff == 4'd0 ? 1'b1 : idm_ff) && (b == track_id(hpos_ff[1:0]));
               end
               r.trk_num = started_in;
               if (hpos_ff >= 4'd7) begin
                  hpos_in = 4'd0;
                  if (!idm_ff) begin
                     r.err   = ERR_TRKID;
                     halt_in = 1'b1;
                  end else begin
                     tick_in = '0; delta_in = '0; vlq_in = '0; endp_in = 1'b0;
                     phase_in = PH_DELTA;
                  end
               end else begin
                  hpos_in = hpos_ff + 4'd1;
               end
            end
            PH_DONE: begin
               r.role = ROLE_IGNORE;
            end
            default: begin
               // Event phases share the event field view and finish logic.
               logic [7:0]  es;
               logic        fin;
               logic        dodelta;
               logic [31:0] dacc;
               es = est_ff; fin = 1'b0; dodelta = 1'b0; dacc = vlq_next;
               if (phase_ff == PH_DELTA) begin
                  dodelta = 1'b1;
               end else if (phase_ff == PH_STATUS) begin
                  if (!b[7]) begin
                     if (rs_ff != 8'd0) begin
                        es = rs_ff; est_in = rs_ff;
                        plen_in = chan_count(rs_ff);
                        left_in = plen_in - 32'd1;
                        r.role = ROLE_CDATA;
                        if (left_in == 32'd0) fin = 1'b1; else phase_in = PH_CDATA;
                     end else begin
                        dodelta = 1'b1;
                        dacc = {25'd0, b[6:0]};
                        r.err = ERR_UNKNOWN;
                     end
                  end else begin
                     es = b; est_in = b;
                     rs_in = (b < 8'hF0) ? b : 8'd0;
                     r.role = ROLE_STATUS;
                     if (b < 8'hF0) begin
                        plen_in = chan_count(b); left_in = plen_in;
                        phase_in = PH_CDATA;
                     end else begin
                        plen_in = '0; left_in = '0; mk_in = '0; vlq_in = '0;
                        if (b == 8'hF0 || b == 8'hF7) phase_in = PH_SXLEN;
                        else if (b == 8'hFF) phase_in = PH_MTYPE;
                        else begin
                           r.err = ERR_UNKNOWN; fin = 1'b1;
                        end
                     end
                  end
               end else if (phase_ff == PH_CDATA || phase_ff == PH_SXDATA
                            || phase_ff == PH_MDATA) begin
                  r.role = (phase_ff == PH_CDATA) ? ROLE_CDATA :
                           (phase_ff == PH_SXDATA) ? ROLE_SXDATA : ROLE_MDATA;
                  left_in = left_dec;
                  if (left_dec == 32'd0) fin = 1'b1;
               end else if (phase_ff == PH_MTYPE) begin
                  mk_in = b; endp_in = (b == META_EOT); vlq_in = '0;
                  r.role = ROLE_MTYPE; phase_in = PH_MLEN;
               end else begin
                  // Sysex or meta length byte.
                  r.role = (phase_ff == PH_SXLEN) ? ROLE_SXLEN : ROLE_MLEN;
                  vlq_in = vlq_next;
                  if (!cont) begin
                     plen_in = vlq_next; left_in = vlq_next; vlq_in = '0;
                     if (vlq_next == 32'd0) fin = 1'b1;
                     else phase_in = (phase_ff == PH_SXLEN) ? PH_SXDATA : PH_MDATA;
                  end
               end
               if (dodelta) begin
                  r.role = ROLE_DELTA;
                  vlq_in = dacc;
                  r.delta = dacc;
                  if (!cont) begin
                     delta_in = dacc; tick_in = tick_ff + dacc; vlq_in = '0;
                     phase_in = PH_STATUS;
                  end
                  r.stamp   = tick_in;
                  r.trk_num = started_ff;
               end else begin
                  r.ev_type = (es[7:4] != 4'hF) ? {es[7:4], 4'h0} : es;
                  r.chan    = es[3:0];
                  r.meta    = (es == 8'hFF) ? mk_in : 8'd0;
                  r.stamp   = tick_ff;
                  r.delta   = delta_ff;
                  r.length  = plen_in;
                  r.trk_num = started_ff;
               end
               if (fin) begin
                  r.ev_end = 1'b1; phase_in = PH_DELTA;
                  if (endp_in) begin
                     r.trk_end = 1'b1; endp_in = 1'b0;
                     if (started_ff >= ntrk_ff) phase_in = PH_DONE;
                     else begin
                        phase_in = PH_THDR; hpos_in = 4'd0;
                     end
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FHDR; hpos_ff <= '0; fmt_ff <= '0; ntrk_ff <= '0;
         started_ff <= '0; idm_ff <= 1'b1; endp_ff <= 1'b0; halt_ff <= 1'b0;
         vlq_ff <= '0; tick_ff <= '0; delta_ff <= '0; left_ff <= '0;
         plen_ff <= '0; rs_ff <= '0; est_ff <= '0; mk_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in; hpos_ff <= hpos_in; fmt_ff <= fmt_in;
            ntrk_ff <= ntrk_in; started_ff <= started_in; idm_ff <= idm_in;
            endp_ff <= endp_in; halt_ff <= halt_in; vlq_ff <= vlq_in;
            tick_ff <= tick_in; delta_ff <= delta_in; left_ff <= left_in;
            plen_ff <= plen_in; rs_ff <= rs_in; est_ff <= est_in; mk_ff <= mk_in;
         end
         if (take) ovalid_ff <= 1'b1;
         else if (out_ready) ovalid_ff <= 1'b0;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (take) res_ff <= r;
   end
endmodule
`default_nettype wire

// ===== design/midi_file_track_parser.sv =====
// Top level of the MIDI file track parser: queue front end plus parse engine.
// Depends on mftp_pkg, mftp_queue and mftp_engine.
//
// Usage: bytes of a Standard MIDI File enter on req_data_byte with a
// req_valid/req_ready handshake; each accepted transaction yields exactly one
// labeled result on the rsp_ ports with rsp_valid/rsp_ready.
// The byte is stored in the two-entry input queue, the engine takes it from
// the queue, and the engine's result register then holds the labeled result
// until the receiver accepts it. Throughput is one byte per cycle while the
// receiver does not stall.
// When the receiver stalls, the result register holds, the engine stops,
// and the queue absorbs up to two more bytes before req_ready drops.
// Synchronous reset returns the parser to expecting the file header,
// empties the queue and clears any halt left by a fatal header error.
`timescale 1ns / 1ps
`default_nettype none
module midi_file_track_parser
   import mftp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_byte_role,
   output logic [7:0]       rsp_data_value,
   output logic [7:0]       rsp_event_type,
   output logic [3:0]       rsp_channel,
   output logic [7:0]       rsp_meta_type,
   output logic [31:0]      rsp_timestamp,
   output logic [31:0]      rsp_tick_delta,
   output logic [31:0]      rsp_data_count,
   output logic             rsp_event_end,
   output logic             rsp_track_end,
   output logic [15:0]      rsp_track_number,
   output logic [2:0]       rsp_error_code
);
   item_type   in_item, q_item;
   logic       q_valid, q_ready;
   result_type res;

   assign in_item.data = req_data_byte;

   mftp_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_item(in_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   mftp_engine u_engine (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_res(res)
   );

   assign rsp_byte_role    = res.role;
   assign rsp_data_value   = res.value;
   assign rsp_event_type   = res.ev_type;
   assign rsp_channel      = res.chan;
   assign rsp_meta_type    = res.meta;
   assign rsp_timestamp    = res.stamp;
   assign rsp_tick_delta   = res.delta;
   assign rsp_data_count   = res.length;
   assign rsp_event_end    = res.ev_end;
   assign rsp_track_end    = res.trk_end;
   assign rsp_track_number = res.trk_num;
   assign rsp_error_code   = res.err;

   // A track end always completes an event.
   a_trk_end_ev: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_track_end |-> rsp_event_end)
      else $error("track end without event end");

   // A stalled result is held.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_value))
      else $error("result changed under stall");

   // Header errors are only reported on header bytes.
   a_hdr_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_FHDR |-> rsp_byte_role == ROLE_FHDR)
      else $error("file header error on wrong role");
endmodule
`default_nettype wire

// ===== sim/tb_midi_file_track_parser.sv =====
// Self-checking testbench for midi_file_track_parser: a byte-level predictor in a
// scoreboard class checks every labeled result. Depends on mftp_pkg and the design.
`timescale 1ns / 1ps
module tb_midi_file_track_parser;
   import mftp_pkg::*;

   localparam int unsigned ITEM_TARGET  = 1650;
   localparam int unsigned QUIET_GAP    = 400;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 6;

   // Parser phases as the predictor tracks them.
   typedef enum logic [3:0] {
      P_FHDR, P_THDR, P_DELTA, P_STATUS, P_CDATA, P_SXLEN,
      P_SXDATA, P_MTYPE, P_MLEN, P_MDATA, P_DONE
   } phase_type;

   localparam logic [7:0] ST_SYSEX  = 8'hF0;
   localparam logic [7:0] ST_ESCAPE = 8'hF7;
   localparam logic [7:0] ST_META   = 8'hFF;
   localparam logic [7:0] ST_UNDEF  = 8'hF4;
   localparam logic [7:0] META_TEXT = 8'h01;

   // Predicts the label of every byte and checks results in order.
   class label_board;
      result_type  expected_labels[$];
      int unsigned mismatches;
      int unsigned labels_checked;
      phase_type   phase;
      logic [3:0]  hdr_pos;
      logic [15:0] fmt, ntracks, started;
      bit          id_ok, eot_pending, halted;
      logic [31:0] acc, tick, cur_delta, left, paylen;
      logic [7:0]  running, ev_status, meta_kind;
      result_type  lbl;

      function new();
         phase = P_FHDR;
         hdr_pos = '0;
         fmt = '0;
         ntracks = '0;
         started = '0;
         id_ok = 1'b1;
         eot_pending = 1'b0;
         halted = 1'b0;
         acc = '0;
         tick = '0;
         cur_delta = '0;
         left = '0;
         paylen = '0;
         running = '0;
         ev_status = '0;
         meta_kind = '0;
         mismatches = 0;
         labels_checked = 0;
      endfunction

      function logic [7:0] tag_byte(bit trk, logic [1:0] p);
         case (p)
            2'd0: return 8'h4D;
            2'd1: return 8'h54;
            2'd2: return trk ? 8'h72 : 8'h68;
            default: return trk ? 8'h6B : 8'h64;
         endcase
      endfunction

      function logic [31:0] chan_bytes(logic [7:0] s);
         return (s[7:4] == 4'hC || s[7:4] == 4'hD) ? 32'd1 : 32'd2;
      endfunction

      // Copy the current event's context into the label.
      function void fill_event();
         lbl.ev_type = (ev_status[7:4] != 4'hF) ? {ev_status[7:4], 4'h0} : ev_status;
         lbl.chan    = ev_status[3:0];
         lbl.meta    = (ev_status == ST_META) ? meta_kind : 8'h00;
         lbl.stamp   = tick;
         lbl.delta   = cur_delta;
         lbl.length  = paylen;
         lbl.trk_num = started;
      endfunction

      function void finish_event();
         lbl.ev_end = 1'b1;
         phase = P_DELTA;
         if (eot_pending) begin
            lbl.trk_end = 1'b1;
            eot_pending = 1'b0;
            if (started >= ntracks) begin
               phase = P_DONE;
            end else begin
               phase = P_THDR;
               hdr_pos = '0;
            end
         end
      endfunction

      function void take_delta(logic [7:0] b);
         acc = {acc[24:0], b[6:0]};
         lbl.role = ROLE_DELTA;
         lbl.delta = acc;
         if (!b[7]) begin
            cur_delta = acc;
            tick = tick + acc;
            acc = '0;
            phase = P_STATUS;
         end
         lbl.stamp = tick;
         lbl.trk_num = started;
      endfunction

      // Returns 1 when the last length byte has come in.
      function bit take_length(logic [7:0] b);
         acc = {acc[24:0], b[6:0]};
         if (b[7]) return 1'b0;
         paylen = acc;
         left = acc;
         acc = '0;
         return 1'b1;
      endfunction

      function void take_chan_data();
         lbl.role = ROLE_CDATA;
         left = left - 1;
         if (left == 0) finish_event();
         else phase = P_CDATA;
      endfunction

      // Note one accepted byte and queue the label it must get.
      function void predict_label(logic [7:0] b);
         logic [3:0] p;
         bit done;
         lbl = '0;
         lbl.value = b;
         p = hdr_pos;
         if (halted) begin
            lbl.role = ROLE_IGNORE;
            lbl.err = ERR_HALTED;
         end else begin
            case (phase)
               P_FHDR: begin
                  lbl.role = ROLE_FHDR;
                  if (p < 4) id_ok = (p == 0 ? 1'b1 : id_ok) && (b == tag_byte(0, p[1:0]));
                  else if (p == 8 || p == 9) fmt = {fmt[7:0], b};
                  else if (p == 10 || p == 11) ntracks = {ntracks[7:0], b};
                  if (p >= 13) begin
                     hdr_pos = '0;
                     if (!id_ok || (fmt == 0 && ntracks != 1)) begin
                        lbl.err = ERR_FHDR;
                        halted = 1'b1;
                     end else if (ntracks == 0) begin
                        phase = P_DONE;
                     end else begin
                        phase = P_THDR;
                     end
                  end else begin
                     hdr_pos = p + 4'd1;
                  end
               end
               P_THDR: begin
                  lbl.role = ROLE_THDR;
                  if (p == 0) started = started + 16'd1;
                  if (p < 4) id_ok = (p == 0 ? 1'b1 : id_ok) && (b == tag_byte(1, p[1:0]));
                  lbl.trk_num = started;
                  if (p >= 7) begin
                     hdr_pos = '0;
                     if (!id_ok) begin
                        lbl.err = ERR_TRKID;
                        halted = 1'b1;
                     end else begin
                        tick = '0;
                        cur_delta = '0;
                        acc = '0;
                        eot_pending = 1'b0;
                        phase = P_DELTA;
                     end
                  end else begin
                     hdr_pos = p + 4'd1;
                  end
               end
               P_DELTA: take_delta(b);
               P_STATUS: begin
                  if (b < 8'h80) begin
                     if (running != 0) begin
                        ev_status = running;
                        paylen = chan_bytes(ev_status);
                        left = paylen;
                        fill_event();
                        take_chan_data();
                     end else begin
                        // Data byte with no running status: it starts the next delta.
                        acc = '0;
                        take_delta(b);
                        lbl.err = ERR_UNKNOWN;
                     end
                  end else begin
                     ev_status = b;
                     running = (b < 8'hF0) ? b : 8'h00;
                     lbl.role = ROLE_STATUS;
                     if (b < 8'hF0) begin
                        paylen = chan_bytes(b);
                        left = paylen;
                        phase = P_CDATA;
                        fill_event();
                     end else begin
                        paylen = '0;
                        left = '0;
                        meta_kind = '0;
                        acc = '0;
                        fill_event();
                        if (b == ST_SYSEX || b == ST_ESCAPE) phase = P_SXLEN;
                        else if (b == ST_META) phase = P_MTYPE;
                        else begin
                           lbl.err = ERR_UNKNOWN;
                           finish_event();
                        end
                     end
                  end
               end
               P_CDATA: begin
                  fill_event();
                  take_chan_data();
               end
               P_SXLEN, P_MLEN: begin
                  done = take_length(b);
                  fill_event();
                  lbl.role = (phase == P_SXLEN) ? ROLE_SXLEN : ROLE_MLEN;
                  if (done) begin
                     if (left == 0) finish_event();
                     else phase = (phase == P_SXLEN) ? P_SXDATA : P_MDATA;
                  end
               end
               P_SXDATA, P_MDATA: begin
                  fill_event();
                  lbl.role = (phase == P_SXDATA) ? ROLE_SXDATA : ROLE_MDATA;
                  left = left - 1;
                  if (left == 0) finish_event();
               end
               P_MTYPE: begin
                  meta_kind = b;
                  eot_pending = (b == META_EOT);
                  acc = '0;
                  fill_event();
                  lbl.role = ROLE_MTYPE;
                  phase = P_MLEN;
               end
               default: lbl.role = ROLE_IGNORE;
            endcase
         end
         expected_labels.push_back(lbl);
      endfunction

      function void field(string name, logic [31:0] e, logic [31:0] a);
         if (e !== a) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, e, a);
            mismatches++;
         end
      endfunction

      // Compare one result transaction with the oldest expected label.
      function void compare_label(result_type got);
         result_type e;
         if (expected_labels.size() == 0) begin
            $error("result transaction with no byte outstanding");
            mismatches++;
            return;
         end
         e = expected_labels.pop_front();
         labels_checked++;
         field("byte_role", e.role, got.role);
         field("data_value", e.value, got.value);
         field("event_type", e.ev_type, got.ev_type);
         field("channel", e.chan, got.chan);
         field("meta_type", e.meta, got.meta);
         field("timestamp", e.stamp, got.stamp);
         field("tick_delta", e.delta, got.delta);
         field("data_count", e.length, got.length);
         field("event_end", e.ev_end, got.ev_end);
         field("track_end", e.trk_end, got.trk_end);
         field("track_number", e.trk_num, got.trk_num);
         field("error_code", e.err, got.err);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_byte_role;
   logic [7:0]  rsp_data_value;
   logic [7:0]  rsp_event_type;
   logic [3:0]  rsp_channel;
   logic [7:0]  rsp_meta_type;
   logic [31:0] rsp_timestamp;
   logic [31:0] rsp_tick_delta;
   logic [31:0] rsp_data_count;
   logic        rsp_event_end;
   logic        rsp_track_end;
   logic [15:0] rsp_track_number;
   logic [2:0]  rsp_error_code;

   label_board  board;
   bit          gaps_on;
   bit          skip_delta;
   logic [7:0]  stim_running;
   int unsigned bytes_sent;
   int unsigned tracks_sent;
   int unsigned quiet_cycles;

   midi_file_track_parser dut (.*);

   // 20 ns clock.
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Receiver: stalls at random once gaps are enabled.
   always @(negedge clock) begin
      rsp_ready <= !(gaps_on && $urandom_range(0, 99) < 14);
   end

   // Check every accepted result transaction.
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_byte_role, rsp_data_value, rsp_event_type, rsp_channel, rsp_meta_type,
                rsp_timestamp, rsp_tick_delta, rsp_data_count, rsp_event_end,
                rsp_track_end, rsp_track_number, rsp_error_code};
         board.compare_label(got);
      end
   end

   // Watchdog: too long without any transaction on either side.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("tb_midi_file_track_parser: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one byte and hold it until the transaction completes.
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while (gaps_on && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      board.predict_label(b);
      bytes_sent++;
      if (bytes_sent >= QUIET_GAP) gaps_on = 1'b1;
   endtask

   // Variable-length quantity, optionally with redundant leading zero groups.
   task automatic send_vlq(input logic [31:0] v, input int pad);
      int n;
      logic [31:0] grp;
      n = 1;
      while (n < 5 && (v >> (7 * n)) != 0) n++;
      repeat (pad) send_byte(8'h80);
      for (int i = n - 1; i >= 0; i--) begin
         grp = v >> (7 * i);
         send_byte({i != 0, grp[6:0]});
      end
   endtask

   function automatic logic [31:0] pick_delta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(0, 127);
      if (r < 85) return $urandom_range(0, 16383);
      if (r < 97) return $urandom_range(0, 32'h1FFFFF);
      return $urandom;
   endfunction

   task automatic send_track_header(input bit corrupt);
      int bad;
      bad = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++)
         send_byte(board.tag_byte(1, i[1:0]) ^ ((corrupt && i == bad) ? 8'h01 : 8'h00));
      repeat (4) send_byte(8'($urandom_range(0, 255)));
   endtask

   // One delta and one event, mostly well formed.
   task automatic send_random_event();
      int pick, n;
      logic [7:0] st;
      pick = $urandom_range(0, 99);
      if (skip_delta) skip_delta = 1'b0;
      else send_vlq(pick_delta(), ($urandom_range(0, 9) == 0) ? 1 : 0);
      if (pick < 40) begin
         st = 8'($urandom_range(8'h80, 8'hEF));
         send_byte(st);
         stim_running = st;
         repeat (board.chan_bytes(st)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 58) begin
         if (stim_running != 0) begin
            // Running status: data bytes only.
            send_byte(8'($urandom_range(0, 127)));
            if (board.chan_bytes(stim_running) == 2) send_byte(8'($urandom_range(0, 255)));
         end else begin
            // Stray data byte, read as the next delta.
            send_byte(8'($urandom_range(0, 127)));
            skip_delta = 1'b1;
         end
      end else if (pick < 70) begin
         send_byte($urandom_range(0, 1) ? ST_SYSEX : ST_ESCAPE);
         stim_running = 8'h00;
         n = $urandom_range(0, 5);
         send_vlq(n, ($urandom_range(0, 7) == 0) ? 1 : 0);
         repeat (n) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
         send_byte(ST_META);
         stim_running = 8'h00;
         st = 8'($urandom_range(0, 255));
         send_byte((st == META_EOT) ? META_TEXT : st);
         n = $urandom_range(0, 5);
         send_vlq(n, ($urandom_range(0, 7) == 0) ? 1 : 0);
         repeat (n) send_byte(8'($urandom_range(0, 255)));
      end else begin
         st = 8'($urandom_range(8'hF1, 8'hFE));
         send_byte((st == ST_ESCAPE) ? 8'hF1 : st);
         stim_running = 8'h00;
      end
   endtask

   // Whole track: header, random events, end-of-track meta.
   task automatic send_track(input int events);
      send_track_header(1'b0);
      repeat (events) send_random_event();
      if (skip_delta) skip_delta = 1'b0;
      else send_vlq(pick_delta(), 0);
      send_byte(ST_META);
      send_byte(META_EOT);
      if ($urandom_range(0, 3) == 0) begin
         send_byte(8'h01);
         send_byte(8'($urandom_range(0, 255)));
      end else begin
         send_byte(8'h00);
      end
      stim_running = 8'h00;
      tracks_sent++;
   endtask

   initial begin
      logic [15:0] fmt;
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      rsp_ready = 1'b0;
      gaps_on = 1'b0;
      skip_delta = 1'b0;
      stim_running = 8'h00;
      bytes_sent = 0;
      tracks_sent = 0;
      quiet_cycles = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // File header: a random nonzero format, the largest track count, so the file never runs out.
      fmt = 16'($urandom_range(1, 16'hFFFF));
      for (int i = 0; i < 4; i++) send_byte(board.tag_byte(0, i[1:0]));
      send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'h06);
      send_byte(fmt[15:8]); send_byte(fmt[7:0]);
      send_byte(8'hFF); send_byte(8'hFF);
      send_byte(8'h01); send_byte(8'hE0);

      // Directed track: note, running status, widest delta, one-byte event,
      // empty sysex, text meta, undefined status, a meta with the two-byte length
      // 128, whose data takes in the escape sysex and end-of-track bytes sent after it.
      send_track_header(1'b0);
      send_vlq(0, 0); send_byte(8'h90); send_byte(8'h3C); send_byte(8'h7F);
      send_vlq(0, 0); send_byte(8'h40); send_byte(8'h00);
      send_vlq(32'hFFFFFFFF, 0); send_byte(8'hC5); send_byte(8'h12);
      send_vlq(1, 0); send_byte(ST_SYSEX); send_byte(8'h00);
      send_vlq(0, 0); send_byte(ST_META); send_byte(META_TEXT); send_byte(8'h02);
      send_byte(8'h41); send_byte(8'h42);
      send_vlq(0, 0); send_byte(ST_UNDEF);
      send_byte(8'h05);
      send_byte(ST_META); send_byte(8'h7F); send_byte(8'h81); send_byte(8'h00);
      send_vlq(0, 0); send_byte(ST_ESCAPE); send_byte(8'h01); send_byte(8'hFF);
      send_vlq(0, 0); send_byte(ST_META); send_byte(META_EOT); send_byte(8'h00);
      tracks_sent++;

      // Random tracks of varied length.
      while (bytes_sent < ITEM_TARGET) send_track($urandom_range(3, 40));

      // A corrupt track id halts the parser; later bytes are ignored.
      send_track_header(1'b1);
      repeat (6) send_byte(8'($urandom_range(0, 255)));
      @(negedge clock);
      req_valid <= 1'b0;

      while (board.expected_labels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Parsed %0d bytes over %0d tracks, ending with a corrupt track header.",
               bytes_sent, tracks_sent);
      $display("Checked %0d labeled results, %0d field mismatches.",
               board.labels_checked, board.mismatches);
      if (board.mismatches == 0) begin
         $display("tb_midi_file_track_parser: done, clean");
      end else begin
         $display("tb_midi_file_track_parser: done, errors");
      end
      $finish;
   end

endmodule
